// File: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes, word types and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_WORDS    = 512;
	localparam int OPCODE_W     = 3;
	localparam int STATUS_W     = 3;
	localparam int BLOCK_W      = 14;
	localparam int WIDX_W       = 9;
	localparam int DATA_W       = 32;
	localparam int BIT_W        = 5;
	localparam int SCAN_W       = 10;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 14;

	localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TEST  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_LOAD  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_WORDS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT = 2'd2;

	localparam logic                 RST_ENABLED     = 1'b0;
	localparam logic [SCAN_W-1:0]    RST_SCAN_WORDS  = 10'd512;
	localparam logic [BLOCK_W-1:0]   RST_BLOCK_LIMIT = 14'd16383;

	// what the back end has to do with a word
	typedef enum logic [2:0] {
		K_REPLY,
		K_ALLOC,
		K_FREE,
		K_TEST,
		K_LOAD,
		K_READ
	} kind_t;

	typedef struct packed {
		logic                enabled;
		logic [SCAN_W-1:0]   scan_words;
		logic [BLOCK_W-1:0]  block_limit;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [STATUS_W-1:0] status;
		logic [WIDX_W-1:0]   widx;
		logic [BIT_W-1:0]    bbit;
		logic [DATA_W-1:0]   wdata;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BLOCK_W-1:0]  granted_block;
		logic                is_allocated;
		logic [DATA_W-1:0]   word_out;
	} res_t;

	// position of the lowest set bit, zero when none is set
	function automatic logic [BIT_W-1:0] lowest_set32(input logic [DATA_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/bba_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_fifo
// Small register queue that decouples two parts of the allocator.
// ----------------------------------------------------------------------------
module bba_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// File: hw/rtl/bba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_front
// Takes request words, checks enable and ranges and sorts them into commands.
// ----------------------------------------------------------------------------
module bba_front #(
	parameter int BITMAP_WORDS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cfg_t                 cfg,
	input  logic                          push,
	output logic                          full,
	input  logic [bba_pkg::OPCODE_W-1:0]  opcode,
	input  logic [bba_pkg::BLOCK_W-1:0]   block_number,
	input  logic [bba_pkg::WIDX_W-1:0]    word_index,
	input  logic [bba_pkg::DATA_W-1:0]    word_data,
	input  logic                          clr_busy,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output bba_pkg::cmd_t                 cmd
);

	logic                        valid_s1;
	bba_pkg::cmd_t               cmd_s1;
	bba_pkg::cmd_t               cls;
	logic                        accept;
	logic [bba_pkg::WIDX_W-1:0]  bword;
	logic                        blk_in;
	logic                        widx_in;

	assign cmd_push = valid_s1 && !cmd_full;
	assign full     = clr_busy || (valid_s1 && cmd_full);
	assign accept   = push && !full;
	assign cmd      = cmd_s1;

	assign bword   = block_number[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W];
	assign blk_in  = (32'(bword) < 32'(BITMAP_WORDS));
	assign widx_in = (32'(word_index) < 32'(BITMAP_WORDS));

	always_comb begin
		cls.kind   = bba_pkg::K_REPLY;
		cls.status = bba_pkg::ST_RANGE;
		cls.widx   = word_index;
		cls.bbit   = block_number[bba_pkg::BIT_W-1:0];
		cls.wdata  = word_data;
		if (!cfg.enabled) begin
			cls.status = bba_pkg::ST_DISABLED;
		end else begin
			case (opcode)
				bba_pkg::OP_ALLOC: begin
					cls.kind = bba_pkg::K_ALLOC;
				end
				bba_pkg::OP_FREE: begin
					cls.widx = bword;
					if (blk_in) begin
						cls.kind = bba_pkg::K_FREE;
					end
				end
				bba_pkg::OP_TEST: begin
					cls.widx = bword;
					if (blk_in && block_number <= cfg.block_limit) begin
						cls.kind = bba_pkg::K_TEST;
					end
				end
				bba_pkg::OP_LOAD: begin
					if (widx_in) begin
						cls.kind = bba_pkg::K_LOAD;
					end
				end
				bba_pkg::OP_READ: begin
					if (widx_in) begin
						cls.kind = bba_pkg::K_READ;
					end
				end
				default: begin
					cls.kind = bba_pkg::K_REPLY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// File: hw/rtl/bba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_back
// Holds the usage bitmap and its full-word summary and carries out commands.
// ----------------------------------------------------------------------------
module bba_back #(
	parameter int BITMAP_WORDS = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bba_pkg::cfg_t  cfg,
	input  logic           cmd_empty,
	input  bba_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output bba_pkg::res_t  res,
	output logic           clr_busy
);

	localparam int DEPTH = (BITMAP_WORDS < bba_pkg::MAX_WORDS) ? BITMAP_WORDS
	                                                             : bba_pkg::MAX_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NG    = (DEPTH + 31) / 32;
	localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_EXEC
	} state_t;

	state_t                         state_q;
	logic [AW-1:0]                  clr_q;
	bba_pkg::cmd_t                  cur_q;
	logic [bba_pkg::WIDX_W-1:0]     widx_q;
	logic [bba_pkg::DATA_W-1:0]     mem_q [DEPTH];
	logic [bba_pkg::DATA_W-1:0]     rdata_q;
	logic [DEPTH-1:0]               full_q;
	logic [NG-1:0]                  grp_hit_q;
	logic [bba_pkg::BIT_W-1:0]      grp_pos_q [NG];

	logic [NG*32-1:0]               full_pad;
	logic [NG*32-1:0]               elig;
	logic [GW-1:0]                  pick_g;
	logic                           pick_any;
	logic [bba_pkg::WIDX_W-1:0]     pick_word;
	logic [bba_pkg::BIT_W-1:0]      alloc_b;
	logic [bba_pkg::BIT_W-1:0]      sel_b;
	logic [bba_pkg::DATA_W-1:0]     bit_mask;
	logic                           mem_we;
	logic [AW-1:0]                  waddr;
	logic [bba_pkg::DATA_W-1:0]     wdata;
	logic [AW-1:0]                  raddr;
	logic                           take;

	assign clr_busy = (state_q == S_CLEAR);
	assign take     = (state_q == S_IDLE) && !cmd_empty && !res_full;

	// words that allocate may pick: not full and inside the scan length
	always_comb begin
		full_pad              = '1;
		full_pad[DEPTH-1:0]   = full_q;
		for (int i = 0; i < NG * 32; i++) begin
			elig[i] = !full_pad[i] && (10'(i) < cfg.scan_words);
		end
	end

	always_comb begin
		pick_g = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				pick_g = GW'(g);
			end
		end
	end

	assign pick_any  = |grp_hit_q;
	assign pick_word = bba_pkg::WIDX_W'({pick_g, grp_pos_q[pick_g]});
	assign alloc_b   = bba_pkg::lowest_set32(~rdata_q);
	assign sel_b     = (cur_q.kind == bba_pkg::K_ALLOC) ? alloc_b : cur_q.bbit;
	assign bit_mask  = bba_pkg::DATA_W'(1) << sel_b;

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		mem_we   = 1'b0;
		waddr    = clr_q;
		wdata    = '0;
		raddr    = cmd.widx[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				cmd_pop = take;
				if (take && cmd.kind == bba_pkg::K_REPLY) begin
					res_push   = 1'b1;
					res.status = cmd.status;
				end
				if (take && cmd.kind == bba_pkg::K_LOAD) begin
					res_push   = 1'b1;
					res.status = bba_pkg::ST_OK;
					mem_we     = 1'b1;
					waddr      = cmd.widx[AW-1:0];
					wdata      = cmd.wdata;
				end
			end
			S_SCAN: begin
				raddr = pick_word[AW-1:0];
			end
			S_PICK: begin
				raddr = pick_word[AW-1:0];
				if (!pick_any) begin
					res_push   = 1'b1;
					res.status = bba_pkg::ST_FULL;
				end
			end
			S_EXEC: begin
				res_push = 1'b1;
				waddr    = widx_q[AW-1:0];
				case (cur_q.kind)
					bba_pkg::K_ALLOC: begin
						mem_we            = 1'b1;
						wdata             = rdata_q | bit_mask;
						res.status        = bba_pkg::ST_OK;
						res.granted_block = {widx_q, alloc_b};
					end
					bba_pkg::K_FREE: begin
						mem_we     = 1'b1;
						wdata      = rdata_q & ~bit_mask;
						res.status = bba_pkg::ST_OK;
					end
					bba_pkg::K_TEST: begin
						res.is_allocated = rdata_q[cur_q.bbit];
						res.status       = rdata_q[cur_q.bbit] ? bba_pkg::ST_OK
						                                       : bba_pkg::ST_NOT_ALLOC;
					end
					bba_pkg::K_READ: begin
						res.status   = bba_pkg::ST_OK;
						res.word_out = rdata_q;
					end
					default: begin
						res.status = bba_pkg::ST_RANGE;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						cur_q  <= cmd;
						widx_q <= cmd.widx;
						case (cmd.kind)
							bba_pkg::K_ALLOC: state_q <= S_SCAN;
							bba_pkg::K_FREE:  state_q <= S_EXEC;
							bba_pkg::K_TEST:  state_q <= S_EXEC;
							bba_pkg::K_READ:  state_q <= S_EXEC;
							default:          state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					widx_q  <= pick_word;
					state_q <= pick_any ? S_EXEC : S_IDLE;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// full-word summary follows every bitmap write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (mem_we) begin
			full_q[waddr] <= &wdata;
		end
	end

	// per-group lowest eligible word, registered ahead of the group pick
	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_hit_q[g] <= |elig[g*32 +: 32];
			grp_pos_q[g] <= bba_pkg::lowest_set32(elig[g*32 +: 32]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit allocator over a free-block bitmap with a full-word summary.
// ----------------------------------------------------------------------------
//  channel   handshake            fields
//  request   push / full          opcode, block_number, word_index, word_data
//  result    empty / pop          status, granted_block, is_allocated, word_out
//  config    cfg_write            cfg_index, cfg_data
//
// allocate goes through the back end as group scan, group pick, bitmap read and
// write-back. free, test and read word do a bitmap read, then act; load word
// and rejected words are answered as they are taken. after reset the bitmap is cleared one word a cycle,
// min(BITMAP_WORDS, 512) words, with full held high. a two-word command queue
// sits between front and back, and a two-word result queue before the outputs.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
	parameter int BITMAP_WORDS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [bba_pkg::OPCODE_W-1:0]      opcode,
	input  logic [bba_pkg::BLOCK_W-1:0]       block_number,
	input  logic [bba_pkg::WIDX_W-1:0]        word_index,
	input  logic [bba_pkg::DATA_W-1:0]        word_data,
	output logic                              empty,
	input  logic                              pop,
	output logic [bba_pkg::STATUS_W-1:0]      status,
	output logic [bba_pkg::BLOCK_W-1:0]       granted_block,
	output logic                              is_allocated,
	output logic [bba_pkg::DATA_W-1:0]        word_out,
	input  logic                              cfg_write,
	input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bba_pkg::cfg_t                     cfg_q;
	bba_pkg::cmd_t                     front_cmd;
	bba_pkg::cmd_t                     back_cmd;
	bba_pkg::res_t                     back_res;
	bba_pkg::res_t                     out_res;
	logic                              clr_busy;
	logic                              cmd_push;
	logic                              cmd_full;
	logic                              cmd_pop;
	logic                              cmd_empty;
	logic [$bits(bba_pkg::cmd_t)-1:0]  cmd_dout;
	logic                              res_push;
	logic                              res_full;
	logic [$bits(bba_pkg::res_t)-1:0]  res_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled     <= bba_pkg::RST_ENABLED;
			cfg_q.scan_words  <= bba_pkg::RST_SCAN_WORDS;
			cfg_q.block_limit <= bba_pkg::RST_BLOCK_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				bba_pkg::REG_ENABLED:     cfg_q.enabled     <= cfg_data[0];
				bba_pkg::REG_SCAN_WORDS:  cfg_q.scan_words  <= cfg_data[bba_pkg::SCAN_W-1:0];
				bba_pkg::REG_BLOCK_LIMIT: cfg_q.block_limit <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	bba_front #(
		.BITMAP_WORDS (BITMAP_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.block_number (block_number),
		.word_index   (word_index),
		.word_data    (word_data),
		.clr_busy     (clr_busy),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (front_cmd)
	);

	bba_fifo #(
		.W     ($bits(bba_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (front_cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_dout),
		.empty  (cmd_empty)
	);

	assign back_cmd = bba_pkg::cmd_t'(cmd_dout);

	bba_back #(
		.BITMAP_WORDS (BITMAP_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res),
		.clr_busy  (clr_busy)
	);

	bba_fifo #(
		.W     ($bits(bba_pkg::res_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_dout),
		.empty  (empty)
	);

	assign out_res       = bba_pkg::res_t'(res_dout);
	assign status        = out_res.status;
	assign granted_block = out_res.granted_block;
	assign is_allocated  = out_res.is_allocated;
	assign word_out      = out_res.word_out;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap block allocator. A local bitmap
// predictor follows every accepted request word and holds the expected reply
// words, which the monitor checks field by field in order. A short directed
// run is followed by random phases under several register settings and
// push / pop idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

	import bba_pkg::*;

	localparam int STORE_WORDS    = 512;
	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = OP_READ + 1'b1;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = '1;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BLOCK_W-1:0]  block_number;
		logic [WIDX_W-1:0]   word_index;
		logic [DATA_W-1:0]   word_data;
	} request_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  push         = 1'b0;
	logic                  full;
	logic [OPCODE_W-1:0]   opcode       = '0;
	logic [BLOCK_W-1:0]    block_number = '0;
	logic [WIDX_W-1:0]     word_index   = '0;
	logic [DATA_W-1:0]     word_data    = '0;
	logic                  empty;
	logic                  pop          = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [BLOCK_W-1:0]    granted_block;
	logic                  is_allocated;
	logic [DATA_W-1:0]     word_out;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// predictor state
	logic [DATA_W-1:0]  bitmap_model [STORE_WORDS] = '{default: '0};
	logic               model_enabled = RST_ENABLED;
	logic [SCAN_W-1:0]  model_scan    = RST_SCAN_WORDS;
	logic [BLOCK_W-1:0] model_limit   = RST_BLOCK_LIMIT;

	request_t pending_requests [$];
	res_t     expected_replies [$];
	request_t bus_item;
	bit       on_bus         = 1'b0;
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;
	int       hot_words      = 4;
	int       mismatch_count = 0;
	int       quiet_cycles   = 0;

	bitmap_block_allocator_unit #(
		.BITMAP_WORDS(STORE_WORDS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.block_number (block_number),
		.word_index   (word_index),
		.word_data    (word_data),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.granted_block(granted_block),
		.is_allocated (is_allocated),
		.word_out     (word_out),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// applies one request to the bitmap copy and returns the reply it earns
	function automatic res_t apply_request(input request_t rq);
		res_t               r;
		int                 scan_lim;
		bit                 found;
		logic [WIDX_W-1:0]  bw;
		logic [BIT_W-1:0]   bsel;
		r        = '0;
		found    = 1'b0;
		bw       = rq.block_number[BLOCK_W-1:BIT_W];
		bsel     = rq.block_number[BIT_W-1:0];
		scan_lim = int'(model_scan);
		if (scan_lim > STORE_WORDS) scan_lim = STORE_WORDS;
		if (scan_lim > MAX_WORDS) scan_lim = MAX_WORDS;
		if (!model_enabled) begin
			r.status = ST_DISABLED;
		end else begin
			case (rq.opcode)
				OP_ALLOC: begin
					for (int w = 0; w < scan_lim && !found; w++) begin
						for (int b = 0; b < DATA_W && !found; b++) begin
							if (!bitmap_model[w][b]) begin
								bitmap_model[w][b] = 1'b1;
								r.granted_block    = BLOCK_W'(w * DATA_W + b);
								found              = 1'b1;
							end
						end
					end
					if (!found) r.status = ST_FULL;
				end
				OP_FREE: begin
					if (int'(bw) >= STORE_WORDS) r.status = ST_RANGE;
					else bitmap_model[bw][bsel] = 1'b0;
				end
				OP_TEST: begin
					if (rq.block_number > model_limit || int'(bw) >= STORE_WORDS) begin
						r.status = ST_RANGE;
					end else begin
						r.is_allocated = bitmap_model[bw][bsel];
						if (!r.is_allocated) r.status = ST_NOT_ALLOC;
					end
				end
				OP_LOAD: begin
					if (int'(rq.word_index) >= STORE_WORDS) r.status = ST_RANGE;
					else bitmap_model[rq.word_index] = rq.word_data;
				end
				OP_READ: begin
					if (int'(rq.word_index) >= STORE_WORDS) r.status = ST_RANGE;
					else r.word_out = bitmap_model[rq.word_index];
				end
				default: r.status = ST_RANGE;
			endcase
		end
		return r;
	endfunction

	function automatic void check_reply(input res_t want);
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			mismatch_count++;
		end
		if (granted_block !== want.granted_block) begin
			$error("granted_block: expected %0d, got %0d", want.granted_block, granted_block);
			mismatch_count++;
		end
		if (is_allocated !== want.is_allocated) begin
			$error("is_allocated: expected %0d, got %0d", want.is_allocated, is_allocated);
			mismatch_count++;
		end
		if (word_out !== want.word_out) begin
			$error("word_out: expected %h, got %h", want.word_out, word_out);
			mismatch_count++;
		end
	endfunction

	// mostly blocks of the low words, where allocations land
	function automatic logic [BLOCK_W-1:0] hot_block();
		if ($urandom_range(99) < 80) return BLOCK_W'($urandom_range(hot_words * DATA_W - 1));
		return BLOCK_W'($urandom);
	endfunction

	function automatic logic [WIDX_W-1:0] hot_word();
		if ($urandom_range(99) < 80) return WIDX_W'($urandom_range(hot_words - 1));
		return WIDX_W'($urandom);
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int       pick;
		rq.opcode       = OP_ALLOC;
		rq.block_number = BLOCK_W'($urandom);
		rq.word_index   = WIDX_W'($urandom);
		rq.word_data    = $urandom;
		pick            = $urandom_range(99);
		if (pick < 35) begin
			rq.opcode = OP_ALLOC;
		end else if (pick < 55) begin
			rq.opcode       = OP_FREE;
			rq.block_number = hot_block();
		end else if (pick < 75) begin
			rq.opcode       = OP_TEST;
			rq.block_number = hot_block();
		end else if (pick < 85) begin
			rq.opcode     = OP_LOAD;
			rq.word_index = hot_word();
			case ($urandom_range(4))
				0, 1: rq.word_data = '1;
				2: rq.word_data = '0;
				default: ;
			endcase
		end else if (pick < 95) begin
			rq.opcode     = OP_READ;
			rq.word_index = hot_word();
		end else begin
			rq.opcode = OPCODE_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
		end
		return rq;
	endfunction

	task automatic push_request(input logic [OPCODE_W-1:0] op, input logic [BLOCK_W-1:0] blk,
			input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] wdata);
		request_t rq;
		rq = '{opcode: op, block_number: blk, word_index: widx, word_data: wdata};
		pending_requests.push_back(rq);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ENABLED:     model_enabled = value[0];
			REG_SCAN_WORDS:  model_scan    = value[SCAN_W-1:0];
			REG_BLOCK_LIMIT: model_limit   = value[BLOCK_W-1:0];
			default: ;
		endcase
	endtask

	// sender holds off until every reply word is back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || on_bus || expected_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
			input int hot);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		hot_words      = hot;
		repeat (n_items) pending_requests.push_back(random_request());
		wait_idle();
	endtask

	// driver
	always @(posedge clk) begin
		if (push && !full) begin
			expected_replies.push_back(apply_request(bus_item));
			on_bus = 1'b0;
		end
		if (!on_bus && pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			bus_item     = pending_requests.pop_front();
			on_bus       = 1'b1;
			opcode       <= bus_item.opcode;
			block_number <= bus_item.block_number;
			word_index   <= bus_item.word_index;
			word_data    <= bus_item.word_data;
		end
		push <= on_bus;
	end

	// monitor
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_replies.size() == 0) begin
				$error("reply word with nothing expected: status %0d", status);
				mismatch_count++;
			end else begin
				check_reply(expected_replies.pop_front());
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk);
		while (quiet_cycles < WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// store still closed after reset: everything refused
		push_request(OP_ALLOC, '0, '0, '0);
		push_request(OP_FREE, '0, '0, '0);
		push_request(OP_TEST, '0, '0, '0);
		push_request(OP_LOAD, '0, '0, '1);
		push_request(OP_READ, '0, '0, '0);
		push_request(OP_UNUSED_LAST, '0, '0, '0);
		wait_idle();

		write_reg(REG_ENABLED, CFG_DATA_W'(1));
		push_request(OP_ALLOC, '0, '0, '0);
		push_request(OP_ALLOC, '0, '0, '0);
		push_request(OP_TEST, '0, '0, '0);
		push_request(OP_TEST, '1, '0, '0);
		push_request(OP_FREE, BLOCK_W'(1), '0, '0);
		// freeing a block that is already free
		push_request(OP_FREE, BLOCK_W'(1), '0, '0);
		push_request(OP_TEST, BLOCK_W'(1), '0, '0);
		push_request(OP_LOAD, '0, '0, '1);
		push_request(OP_READ, '0, '0, '0);
		push_request(OP_ALLOC, '0, '0, '0);
		push_request(OP_LOAD, '0, '1, 32'hA5A5_A5A5);
		push_request(OP_READ, '0, '1, '0);
		push_request(OP_TEST, '1, '0, '0);
		push_request(OP_UNUSED_FIRST, '1, '1, '1);
		push_request(OP_LOAD, '0, WIDX_W'(1), '0);
		wait_idle();

		// word 0 is all ones, so a one-word scan finds nothing
		write_reg(REG_SCAN_WORDS, CFG_DATA_W'(1));
		push_request(OP_ALLOC, '0, '0, '0);
		wait_idle();
		write_reg(REG_SCAN_WORDS, '0);
		push_request(OP_ALLOC, '0, '0, '0);
		wait_idle();
		write_reg(REG_BLOCK_LIMIT, '0);
		push_request(OP_TEST, '0, '0, '0);
		push_request(OP_TEST, BLOCK_W'(1), '0, '0);
		wait_idle();

		write_reg(REG_SCAN_WORDS, CFG_DATA_W'(MAX_WORDS));
		write_reg(REG_BLOCK_LIMIT, '1);
		run_phase(180, 0, 0, 4);

		write_reg(REG_SCAN_WORDS, CFG_DATA_W'(2));
		write_reg(REG_BLOCK_LIMIT, CFG_DATA_W'(100));
		run_phase(200, 65, 0, 3);

		write_reg(REG_SCAN_WORDS, CFG_DATA_W'({SCAN_W{1'b1}}));
		write_reg(REG_BLOCK_LIMIT, '0);
		run_phase(200, 0, 65, 6);

		// closed again, with junk in the unused data bits
		write_reg(REG_ENABLED, CFG_DATA_W'($urandom) << 1);
		run_phase(40, 22, 22, 4);

		write_reg(REG_ENABLED, (CFG_DATA_W'($urandom) << 1) | CFG_DATA_W'(1));
		write_reg(REG_SCAN_WORDS, CFG_DATA_W'(1));
		write_reg(REG_BLOCK_LIMIT, CFG_DATA_W'($urandom_range(200)));
		run_phase(200, 22, 22, 2);

		write_reg(REG_SCAN_WORDS, '0);
		run_phase(40, 0, 0, 4);

		write_reg(REG_SCAN_WORDS, CFG_DATA_W'(64));
		write_reg(REG_BLOCK_LIMIT, CFG_DATA_W'(8191));
		run_phase(200, 22, 22, 8);

		repeat (END_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) mismatch_count++;
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
